// ===== sv/cvs_pkg.sv =====
`timescale 1ns / 1ps
// types, widths and helpers shared by the cloth verlet stick unit
// no dependencies

package cvs_pkg;

  localparam int PosW    = 32;
  localparam int DampW   = 16;
  localparam int GravW   = 21;
  localparam int RestW   = 25;
  localparam int CfgW    = 25;
  localparam int CfgIdxW = 2;
  localparam int DiffW   = PosW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int SumW    = SqW;
  localparam int SqrtW   = SumW + 1;
  localparam int RootW   = DiffW;
  localparam int ErrW    = RootW + 2;
  localparam int EMagW   = RootW + 1;
  localparam int DenW    = RootW + 1;
  localparam int ProdW   = DiffW + EMagW;
  localparam int QW      = EMagW + 1;
  localparam int DivW    = DenW + QW + 1;
  localparam int PdW     = DiffW + DampW + 1;
  localparam int WideW   = PosW + 6;
  localparam int MetaN   = RootW + QW + 4;
  localparam int Lat     = RootW + QW + 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDamping  = 2'd0,
    CfgGravity  = 2'd1,
    CfgRestHorz = 2'd2,
    CfgRestVert = 2'd3
  } cfg_idx_e;

  localparam logic signed [WideW-1:0] PosMax = WideW'((64'sd1 <<< (PosW - 1)) - 64'sd1);
  localparam logic signed [WideW-1:0] PosMin = -PosMax - WideW'(1);

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    pos_t v;
    logic sat;
  } clamp_t;

  typedef struct packed {
    logic             op;
    logic             pin;
    logic             conn;
    pos_t             ax;
    pos_t             ay;
    pos_t             bx;
    pos_t             by;
    logic [RestW-1:0] rest;
    diff_t            dx;
    diff_t            dy;
    pos_t             ir0;
    pos_t             ir1;
    logic             isat;
    logic             degen;
    logic             eneg;
  } meta_t;

  function automatic clamp_t clamp_pos(input logic signed [WideW-1:0] v);
    clamp_t r;
    r.sat = 1'b1;
    if (v > PosMax) r.v = PosMax[PosW-1:0];
    else if (v < PosMin) r.v = PosMin[PosW-1:0];
    else begin
      r.v   = v[PosW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [DiffW-1:0] abs_diff(input diff_t v);
    return v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

endpackage

// ===== sv/cvs_in_if.sv =====
`timescale 1ns / 1ps
// input channel of the cloth verlet stick unit: one point or stick per transfer
// depends on cvs_pkg

interface cvs_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  cvs_pkg::pos_t     first_x;
  cvs_pkg::pos_t     first_y;
  cvs_pkg::pos_t     second_x;
  cvs_pkg::pos_t     second_y;
  logic              vertical;
  logic              connected;
  logic              first_pinned;

  modport source (output valid, opcode, first_x, first_y, second_x, second_y, vertical,
                  connected, first_pinned, input ready);
  modport sink (input valid, opcode, first_x, first_y, second_x, second_y, vertical,
                connected, first_pinned, output ready);
endinterface

// ===== sv/cvs_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the cloth verlet stick unit
// depends on cvs_pkg

interface cvs_out_if;
  logic          valid;
  logic          ready;
  cvs_pkg::pos_t new_first_x;
  cvs_pkg::pos_t new_first_y;
  cvs_pkg::pos_t new_second_x;
  cvs_pkg::pos_t new_second_y;
  logic          degenerate;
  logic          saturated;

  modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                  degenerate, saturated, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                degenerate, saturated, output ready);
endinterface

// ===== sv/cvs_sqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage
// depends on cvs_pkg

module cvs_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cvs_pkg::SumW-1:0]   radicand_i,
  output logic [cvs_pkg::RootW-1:0]  root_o
);
  import cvs_pkg::*;

  logic [SqrtW-1:0] rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int B = RootW - 1 - s;
    logic [SqrtW-1:0] rem_in;
    logic [SqrtW-1:0] trial;
    logic [RootW-1:0] root_in;

    if (s == 0) begin : g_first
      assign rem_in  = SqrtW'(radicand_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (SqrtW'(root_in) << (B + 1)) + (SqrtW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (RootW'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

// ===== sv/cvs_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on cvs_pkg

module cvs_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cvs_pkg::DivW-1:0]  num_i,
  input  logic [cvs_pkg::DenW-1:0]  den_i,
  output logic [cvs_pkg::QW-1:0]    quo_o
);
  import cvs_pkg::*;

  logic [DivW-1:0] rem_q [QW];
  logic [DenW-1:0] den_q [QW];
  logic [QW-1:0]   quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [DivW-1:0] rem_in;
    logic [DivW-1:0] dsh;
    logic [DenW-1:0] den_in;
    logic [QW-1:0]   quo_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign dsh = DivW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= dsh) begin
          rem_q[s] <= rem_in - dsh;
          quo_q[s] <= quo_in | (QW'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== sv/cloth_verlet_stick_unit.sv =====
`timescale 1ns / 1ps
// Cloth point engine: Verlet integration of a point or relaxation of one stick
// per transfer, Q16.16 positions.
// Channels: in_i takes opcode, both endpoints (or current and previous point)
// and the stick flags; out_o gives the four updated positions and the
// degenerate and saturated flags, one result per input transfer, in order.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (damping,
// gravity step, horizontal and vertical rest length); write only while idle.
// Path: an input transfer passes three front stages, the 33-stage square root,
// three error and numerator stages, the 35-stage divider and the output
// register before its result is offered.
// Throughput: one item per cycle; the whole pipeline moves whenever the output
// register is empty or being taken.
// Stall: when out_o is valid and not ready, every stage holds and in_i.ready
// drops in the same cycle; nothing is lost or repeated.
// Reset: rst_ni clears all valid bits and loads the default registers
// (damping 0.98, gravity step 36409, rest lengths 4.0 and 2.0 pixels).
// depends on cvs_pkg, cvs_in_if, cvs_out_if, cvs_sqrt, cvs_div

module cloth_verlet_stick_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cvs_in_if.sink                        in_i,
  cvs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [cvs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cvs_pkg::CfgW-1:0]      cfg_data_i
);
  import cvs_pkg::*;

  logic [DampW-1:0] damping_q;
  logic [GravW-1:0] grav_q;
  logic [RestW-1:0] rest_h_q;
  logic [RestW-1:0] rest_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= DampW'(64225);
      grav_q    <= GravW'(36409);
      rest_h_q  <= RestW'(262144);
      rest_v_q  <= RestW'(131072);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDamping:  damping_q <= cfg_data_i[DampW-1:0];
        CfgGravity:  grav_q    <= cfg_data_i[GravW-1:0];
        CfgRestHorz: rest_h_q  <= cfg_data_i[RestW-1:0];
        CfgRestVert: rest_v_q  <= cfg_data_i[RestW-1:0];
        default: ;
      endcase
    end
  end

  logic           en;
  logic [Lat-1:0] vld_q;

  assign en         = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_i.valid};
  end

  meta_t meta_q [MetaN];

  // stage 1: capture
  meta_t s1_d, s1_q;
  always_comb begin
    s1_d      = '0;
    s1_d.op   = in_i.opcode;
    s1_d.pin  = in_i.first_pinned;
    s1_d.conn = in_i.connected;
    s1_d.ax   = in_i.first_x;
    s1_d.ay   = in_i.first_y;
    s1_d.bx   = in_i.second_x;
    s1_d.by   = in_i.second_y;
    s1_d.rest = in_i.vertical ? rest_v_q : rest_h_q;
  end

  // stage 2: differences, squares and damping products
  meta_t                 s2_d, s2_q;
  logic [DiffW-1:0]      adx, ady;
  diff_t                 vx, vy;
  logic [SqW-1:0]        sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [PdW-1:0] pdx_d, pdy_d, pdx_q, pdy_q;

  always_comb begin
    s2_d    = s1_q;
    s2_d.dx = DiffW'(s1_q.bx) - DiffW'(s1_q.ax);
    s2_d.dy = DiffW'(s1_q.by) - DiffW'(s1_q.ay);
  end

  assign adx   = abs_diff(s2_d.dx);
  assign ady   = abs_diff(s2_d.dy);
  assign vx    = -s2_d.dx;
  assign vy    = -s2_d.dy;
  assign sqx_d = SqW'(adx) * SqW'(adx);
  assign sqy_d = SqW'(ady) * SqW'(ady);
  assign pdx_d = PdW'(vx) * $signed(PdW'({1'b0, damping_q}));
  assign pdy_d = PdW'(vy) * $signed(PdW'({1'b0, damping_q}));

  // stage 3: radicand and finished integrate result
  meta_t                       meta_d;
  logic [SumW-1:0]             sum_d, sum_q;
  logic signed [PdW-1:0]       rndx, rndy;
  logic signed [PdW-DampW-1:0] dmx, dmy;
  logic signed [WideW-1:0]     r0w, r1w;
  clamp_t                      c0, c1;

  assign sum_d = SumW'(sqx_q) + SumW'(sqy_q);
  // damping product rounded half up
  assign rndx  = (pdx_q + (PdW'(1) <<< (DampW - 1))) >>> DampW;
  assign rndy  = (pdy_q + (PdW'(1) <<< (DampW - 1))) >>> DampW;
  assign dmx   = rndx[PdW-DampW-1:0];
  assign dmy   = rndy[PdW-DampW-1:0];
  assign r0w   = WideW'(s2_q.ax) + WideW'(dmx);
  assign r1w   = WideW'(s2_q.ay) + WideW'(dmy) + $signed(WideW'(grav_q));
  assign c0    = clamp_pos(r0w);
  assign c1    = clamp_pos(r1w);

  always_comb begin
    meta_d      = s2_q;
    meta_d.ir0  = c0.v;
    meta_d.ir1  = c1.v;
    meta_d.isat = c0.sat | c1.sat;
  end

  logic [RootW-1:0] root;

  cvs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (sum_q),
    .root_o     (root)
  );

  // error stage: dist - rest and the divisor
  meta_t                  m_root, meta_e;
  logic signed [ErrW-1:0] err;
  logic [EMagW-1:0]       emag_d, emag_q;
  logic [DenW-1:0]        den_e_d, den_e_q, den_m_q;

  assign m_root  = meta_q[RootW];
  assign err     = $signed(ErrW'(root)) - $signed(ErrW'(m_root.rest));
  assign emag_d  = err[ErrW-1] ? EMagW'(-err) : EMagW'(err);
  assign den_e_d = m_root.pin ? DenW'(root) : {root, 1'b0};

  always_comb begin
    meta_e       = m_root;
    meta_e.degen = m_root.op && m_root.conn && (root == '0);
    meta_e.eneg  = err[ErrW-1];
  end

  // product and numerator stages
  meta_t            m_e;
  logic [ProdW-1:0] px_d, py_d, px_q, py_q;
  logic [DivW-1:0]  nx_d, ny_d, nx_q, ny_q;
  logic [DenW-1:0]  den_n_q;

  assign m_e  = meta_q[RootW+1];
  assign px_d = ProdW'(abs_diff(m_e.dx)) * ProdW'(emag_q);
  assign py_d = ProdW'(abs_diff(m_e.dy)) * ProdW'(emag_q);
  // half the divisor gives round to nearest, ties away from zero
  assign nx_d = DivW'(px_q) + DivW'(den_m_q >> 1);
  assign ny_d = DivW'(py_q) + DivW'(den_m_q >> 1);

  logic [QW-1:0] qx, qy;

  cvs_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_q),
    .den_i (den_n_q),
    .quo_o (qx)
  );

  cvs_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (den_n_q),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      pdx_q     <= pdx_d;
      pdy_q     <= pdy_d;
      sum_q     <= sum_d;
      meta_q[0] <= meta_d;
      for (int j = 1; j < MetaN; j++) begin
        if (j == RootW + 1) meta_q[j] <= meta_e;
        else meta_q[j] <= meta_q[j-1];
      end
      emag_q  <= emag_d;
      den_e_q <= den_e_d;
      den_m_q <= den_e_q;
      px_q    <= px_d;
      py_q    <= py_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      den_n_q <= den_m_q;
    end
  end

  // final stage: apply the move, clamp, pick the result
  meta_t                   mf;
  logic signed [QW:0]      qxs, qys, mx, my;
  clamp_t                  f0, f1, f2, f3;
  pos_t                    o0, o1, o2, o3;
  logic                    odeg, osat;

  assign mf  = meta_q[MetaN-1];
  assign qxs = $signed({1'b0, qx});
  assign qys = $signed({1'b0, qy});
  assign mx  = (mf.dx[DiffW-1] ^ mf.eneg) ? -qxs : qxs;
  assign my  = (mf.dy[DiffW-1] ^ mf.eneg) ? -qys : qys;
  assign f0  = clamp_pos(WideW'(mf.ax) + WideW'(mx));
  assign f1  = clamp_pos(WideW'(mf.ay) + WideW'(my));
  assign f2  = clamp_pos(WideW'(mf.bx) - WideW'(mx));
  assign f3  = clamp_pos(WideW'(mf.by) - WideW'(my));

  always_comb begin
    o0   = mf.ax;
    o1   = mf.ay;
    o2   = mf.bx;
    o3   = mf.by;
    odeg = 1'b0;
    osat = 1'b0;
    priority if (!mf.op) begin
      if (!mf.pin) begin
        o0   = mf.ir0;
        o1   = mf.ir1;
        o2   = mf.ax;
        o3   = mf.ay;
        osat = mf.isat;
      end
    end else if (!mf.conn) begin
      odeg = 1'b0;
    end else if (mf.degen) begin
      odeg = 1'b1;
    end else begin
      o2   = f2.v;
      o3   = f3.v;
      osat = f2.sat | f3.sat;
      if (!mf.pin) begin
        o0   = f0.v;
        o1   = f1.v;
        osat = osat | f0.sat | f1.sat;
      end
    end
  end

  pos_t o0_q, o1_q, o2_q, o3_q;
  logic odeg_q, osat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      o0_q   <= o0;
      o1_q   <= o1;
      o2_q   <= o2;
      o3_q   <= o3;
      odeg_q <= odeg;
      osat_q <= osat;
    end
  end

  assign out_o.valid        = vld_q[Lat-1];
  assign out_o.new_first_x  = o0_q;
  assign out_o.new_first_y  = o1_q;
  assign out_o.new_second_x = o2_q;
  assign out_o.new_second_y = o3_q;
  assign out_o.degenerate   = odeg_q;
  assign out_o.saturated    = osat_q;

endmodule

// ===== sv/cvs_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the cloth verlet stick unit, bound to the top level
// depends on cloth_verlet_stick_unit ports

module cvs_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic degenerate_i,
  input logic saturated_i
);

  // a held result stays offered until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // input side stalls exactly when the output register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

  // a zero-length stick never reports a clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> !saturated_i)
    else $error("degenerate result flagged saturated");

  // a sampled reset leaves no result offered
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind cloth_verlet_stick_unit cvs_port_checker u_cvs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .degenerate_i (out_o.degenerate),
  .saturated_i  (out_o.saturated)
);

// ===== bench/cvs_checker.sv =====
`timescale 1ns / 1ps
// checker for the cloth verlet stick unit: watches both channels, predicts each result
// depends on cvs_pkg, cvs_in_if, cvs_out_if

module cvs_scoreboard (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cvs_in_if.sink                      in_i,
  cvs_out_if.sink                     out_o,
  input  logic                        cfg_we_i,
  input  logic [cvs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cvs_pkg::CfgW-1:0]    cfg_data_i,
  output int                          errors_o,
  output int                          pending_o
);
  import cvs_pkg::*;

  typedef struct {
    pos_t fx, fy, sx, sy;
    logic degen, sat;
  } point_result_t;

  point_result_t expected_q[$];
  logic [DampW-1:0] damp_r;
  logic [GravW-1:0] grav_r;
  logic [RestW-1:0] rest_h_r, rest_v_r;

  assign pending_o = expected_q.size();

  function automatic logic signed [71:0] clamp_word(input logic signed [71:0] v,
                                                    inout logic sat);
    if (v > 72'sd2147483647) begin
      sat = 1'b1;
      return 72'sd2147483647;
    end
    if (v < -72'sd2147483648) begin
      sat = 1'b1;
      return -72'sd2147483648;
    end
    return v;
  endfunction

  // damping*v rounded half up, floor semantics for negatives
  function automatic logic signed [71:0] damped(input logic signed [71:0] v);
    logic signed [71:0] p;
    p = v * $signed({1'b0, damp_r}) + 72'sd32768;
    return p >>> DampW;
  endfunction

  function automatic logic [71:0] root_of(input logic [71:0] s);
    logic [71:0] r, c;
    r = '0;
    for (int k = 35; k >= 0; k--) begin
      c = r | (72'd1 << k);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // d*e/den rounded to nearest, ties away from zero
  function automatic logic signed [71:0] move_of(input logic signed [71:0] d,
                                                 input logic signed [71:0] e,
                                                 input logic [71:0] den);
    logic [143:0] n, q;
    n = (d < 0 ? -d : d) * (e < 0 ? -e : e);
    q = (n + (den >> 1)) / den;
    return ((d < 0) != (e < 0)) ? -$signed(q[71:0]) : $signed(q[71:0]);
  endfunction

  function automatic point_result_t predict_point(input logic op, input pos_t ax,
      input pos_t ay, input pos_t bx, input pos_t by, input logic vert,
      input logic conn, input logic pin);
    point_result_t r;
    logic signed [71:0] dx, dy, mx, my, e;
    logic [71:0] span_len, den;
    logic s;
    r = '{ax, ay, bx, by, 1'b0, 1'b0};
    s = 1'b0;
    if (!op) begin
      if (!pin) begin
        r.fx = pos_t'(clamp_word(72'(ax) + damped(72'(ax) - 72'(bx)), s));
        r.fy = pos_t'(clamp_word(72'(ay) + damped(72'(ay) - 72'(by))
                                 + $signed({1'b0, grav_r}), s));
        r.sx = ax;
        r.sy = ay;
      end
    end else if (conn) begin
      dx = 72'(bx) - 72'(ax);
      dy = 72'(by) - 72'(ay);
      span_len = root_of(dx * dx + dy * dy);
      if (span_len == 0) r.degen = 1'b1;
      else begin
        e = $signed(span_len) - $signed({1'b0, vert ? rest_v_r : rest_h_r});
        den = pin ? span_len : 2 * span_len;
        mx = move_of(dx, e, den);
        my = move_of(dy, e, den);
        if (!pin) begin
          r.fx = pos_t'(clamp_word(72'(ax) + mx, s));
          r.fy = pos_t'(clamp_word(72'(ay) + my, s));
        end
        r.sx = pos_t'(clamp_word(72'(bx) - mx, s));
        r.sy = pos_t'(clamp_word(72'(by) - my, s));
      end
    end
    r.sat = s;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_result_t want;
    if (!rst_ni) begin
      damp_r   <= 16'd64225;
      grav_r   <= 21'd36409;
      rest_h_r <= 25'd262144;
      rest_v_r <= 25'd131072;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgDamping:  damp_r   <= cfg_data_i[DampW-1:0];
          CfgGravity:  grav_r   <= cfg_data_i[GravW-1:0];
          CfgRestHorz: rest_h_r <= cfg_data_i[RestW-1:0];
          CfgRestVert: rest_v_r <= cfg_data_i[RestW-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        expected_q.push_back(predict_point(in_i.opcode, in_i.first_x, in_i.first_y,
            in_i.second_x, in_i.second_y, in_i.vertical, in_i.connected,
            in_i.first_pinned));
      if (out_o.valid && out_o.ready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected transfer", 0, 0);
        else begin
          want = expected_q.pop_front();
          if (out_o.new_first_x !== want.fx)
            report_mismatch("new_first_x", out_o.new_first_x, want.fx);
          if (out_o.new_first_y !== want.fy)
            report_mismatch("new_first_y", out_o.new_first_y, want.fy);
          if (out_o.new_second_x !== want.sx)
            report_mismatch("new_second_x", out_o.new_second_x, want.sx);
          if (out_o.new_second_y !== want.sy)
            report_mismatch("new_second_y", out_o.new_second_y, want.sy);
          if (out_o.degenerate !== want.degen)
            report_mismatch("degenerate", out_o.degenerate, want.degen);
          if (out_o.saturated !== want.sat)
            report_mismatch("saturated", out_o.saturated, want.sat);
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the cloth verlet stick unit
// depends on cvs_pkg, cvs_in_if, cvs_out_if, cvs_scoreboard, cloth_verlet_stick_unit

module tb;
  import cvs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  int errors, pending;
  int send_idle_pct, sink_idle_pct;

  cvs_in_if  in_ch ();
  cvs_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  cloth_verlet_stick_unit dut (.clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
                               .cfg_we_i, .cfg_idx_i, .cfg_data_i);

  cvs_scoreboard checker_u (.clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.sink),
                            .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors),
                            .pending_o(pending));

  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

  function automatic pos_t rand_coord(input int mode);
    case (mode)
      0: return pos_t'($urandom);
      1: return pos_t'($signed($urandom_range(8_000_000)) - 4_000_000);
      default: return pos_t'($signed($urandom_range(40_000)) - 20_000);
    endcase
  endfunction

  // one transfer, with a random idle gap in front
  task automatic send_point(input logic op, input pos_t ax, input pos_t ay, input pos_t bx,
                            input pos_t by, input logic vert, input logic conn,
                            input logic pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.first_x <= ax;
    in_ch.first_y <= ay;
    in_ch.second_x <= bx;
    in_ch.second_y <= by;
    in_ch.vertical <= vert;
    in_ch.connected <= conn;
    in_ch.first_pinned <= pin;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Lat + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_burst(input int n);
    int m;
    pos_t ax, ay;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(9);
      m = m < 2 ? 0 : (m < 5 ? 1 : 2);
      ax = rand_coord(m);
      ay = rand_coord(m);
      if ($urandom_range(9) == 0)
        send_point(1'($urandom), ax, ay, ax, ay, 1'($urandom), 1'($urandom),
                   1'($urandom));
      else
        send_point(1'($urandom), ax, ay, rand_coord(m), rand_coord(m), 1'($urandom),
                   $urandom_range(7) != 0, $urandom_range(3) == 0);
    end
  endtask

  initial begin
    pos_t mx, mn;
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.vertical = 1'b0;
    in_ch.connected = 1'b0;
    in_ch.first_pinned = 1'b0;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_idle_pct = 7;
    sink_idle_pct = 55;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: both operations, pinning, disconnected, zero length, extremes
    send_point(1'b0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    send_point(1'b0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 1'b1);
    send_point(1'b0, mx, mx, mn, mn, 1'b0, 1'b0, 1'b0);
    send_point(1'b0, mn, mn, mx, mx, 1'b0, 1'b0, 1'b0);
    send_point(1'b0, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 1'b0, 1'b1, 1'b0);
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 1'b1, 1'b1, 1'b0);
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd655360, 32'sd65536, 1'b0, 1'b1, 1'b1);
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 1'b0, 1'b0, 1'b0);
    send_point(1'b1, 32'sd77, -32'sd5, 32'sd77, -32'sd5, 1'b0, 1'b1, 1'b0);
    send_point(1'b1, mn, mn, mx, mx, 1'b0, 1'b1, 1'b0);
    send_point(1'b1, mx, mn, mn, mx, 1'b1, 1'b1, 1'b1);
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 1'b0, 1'b1, 1'b0);
    send_point(1'b1, 32'sd5, 32'sd5, 32'sd4, 32'sd5, 1'b1, 1'b1, 1'b1);
    send_point(1'b0, mx, mx, mx, mx, 1'b1, 1'b1, 1'b0);
    random_burst(300);
    drain_pipe();
    // high and low settings of every register
    write_reg(CfgDamping, 25'd65535);
    write_reg(CfgGravity, 25'd1048576);
    write_reg(CfgRestHorz, 25'd16777216);
    write_reg(CfgRestVert, 25'd0);
    send_idle_pct = 55;
    sink_idle_pct = 7;
    random_burst(350);
    drain_pipe();
    write_reg(CfgDamping, 25'd0);
    write_reg(CfgGravity, 25'd0);
    write_reg(CfgRestHorz, 25'd0);
    write_reg(CfgRestVert, 25'd16777216);
    send_idle_pct = 0;
    sink_idle_pct = 0;
    random_burst(300);
    drain_pipe();
    write_reg(CfgDamping, 25'($urandom_range(65535)));
    write_reg(CfgGravity, 25'($urandom_range(1048576)));
    write_reg(CfgRestHorz, 25'($urandom_range(16777216)));
    write_reg(CfgRestVert, 25'($urandom_range(16777216)));
    random_burst(350);
    drain_pipe();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
